/* design/bdeq_pkg.sv */
`timescale 1ns / 1ps

package bdeq_pkg;

    localparam int WORD_W = 32;
    localparam int CAP_W  = 11;
    localparam int ACT_W  = 3;

    // action codes; anything else is look only
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LOOK       = 3'd4;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    // controller to datapath
    typedef struct packed {
        logic step;   // apply the accepted item to head, count and store
        logic load;   // capture the result into the output register
    } bdeq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken this cycle
    } bdeq_sts_t;

endpackage

/* design/bdeq_ram.sv */
`timescale 1ns / 1ps

module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* design/bdeq_ctrl.sv */
`timescale 1ns / 1ps

module bdeq_ctrl
    import bdeq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bdeq_sts_t sts,
    output bdeq_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        s_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready  = s_ready_reg;
    assign cmd.step = s_ready_reg & s_valid;
    assign cmd.load = (state_reg == ST_LOAD) & sts.out_free;

endmodule

/* design/bdeq_dp.sv */
`timescale 1ns / 1ps

module bdeq_dp
    import bdeq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bdeq_cmd_t                cmd,
    output bdeq_sts_t                sts,
    input  logic [ACT_W-1:0]         s_action,
    input  logic signed [WORD_W-1:0] s_value,
    input  logic                     cfg_wr,
    input  logic [CAP_W-1:0]         cfg_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_ok,
    output logic signed [WORD_W-1:0] m_front_value,
    output logic signed [WORD_W-1:0] m_rear_value,
    output logic                     m_is_empty,
    output logic                     m_is_full
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = AW + 1;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_RAW = DEPTH % (2 ** CAP_W);
    localparam int CAP_RST = (CAP_RAW == 0) ? 1 : CAP_RAW;
    localparam logic [AW-1:0]    LAST_POS  = AW'(DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    logic [AW-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic              ok_pend_reg, ok_pend_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_ok_reg;
    logic [WORD_W-1:0] m_front_reg, m_rear_reg;
    logic              m_empty_reg, m_full_reg;

    logic              full, empty;
    logic [AW-1:0]     head_dec, head_inc, tail_pos, rear_pos;
    logic [SUM_W-1:0]  tail_sum, rear_sum;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] rd_front, rd_rear;
    logic [CMP_W-1:0]  cfg_ext;

    assign full  = CMP_W'(count_reg) >= CMP_W'(cap_reg);
    assign empty = (count_reg == '0);

    assign head_dec = (head_reg == '0) ? LAST_POS : head_reg - AW'(1);
    assign head_inc = (head_reg == LAST_POS) ? '0 : head_reg + AW'(1);

    // ring positions of the slot past the rear and of the rear itself
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_pos = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : AW'(tail_sum);
    assign rear_sum = tail_sum - SUM_W'(1);
    assign rear_pos = (rear_sum >= DEPTH_SUM) ? AW'(rear_sum - DEPTH_SUM) : AW'(rear_sum);

    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        ok_pend_next = ok_pend_reg;
        wr_en        = 1'b0;
        wr_addr      = tail_pos;
        if (cmd.step) begin
            ok_pend_next = 1'b1;
            case (s_action)
                ACT_PUSH_FRONT: begin
                    if (full) begin
                        ok_pend_next = 1'b0;
                    end else begin
                        head_next  = head_dec;
                        wr_addr    = head_dec;
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_PUSH_BACK: begin
                    if (full) begin
                        ok_pend_next = 1'b0;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_POP_FRONT: begin
                    if (empty) begin
                        ok_pend_next = 1'b0;
                    end else begin
                        head_next  = head_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                ACT_POP_BACK: begin
                    if (empty) begin
                        ok_pend_next = 1'b0;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    ok_pend_next = 1'b1;
                end
            endcase
        end
    end

    // clamp capacity to 1..DEPTH; writes land only while empty
    assign cfg_ext = CMP_W'(cfg_data);
    always_comb begin
        cap_next = cap_reg;
        if (cfg_wr && empty) begin
            if (cfg_data == '0) begin
                cap_next = CAP_W'(1);
            end else if (cfg_ext > DEPTH_CMP) begin
                cap_next = CAP_W'(DEPTH);
            end else begin
                cap_next = cfg_data;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            cap_reg     <= CAP_W'(CAP_RST);
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_pend_reg <= ok_pend_next;
        if (cmd.load) begin
            m_ok_reg    <= ok_pend_reg;
            m_front_reg <= empty ? EMPTY_WORD : rd_front;
            m_rear_reg  <= empty ? EMPTY_WORD : rd_rear;
            m_empty_reg <= empty;
            m_full_reg  <= full;
        end
    end

    bdeq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (WORD_W'(s_value)),
        .raddr_a (head_reg),
        .rdata_a (rd_front),
        .raddr_b (rear_pos),
        .rdata_b (rd_rear)
    );

    assign sts.out_free  = ~m_valid_reg | m_ready;
    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_front_value = signed'(m_front_reg);
    assign m_rear_value  = signed'(m_rear_reg);
    assign m_is_empty    = m_empty_reg;
    assign m_is_full     = m_full_reg;

endmodule

/* design/bounded_double_ended_queue.sv */
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words held in a ring store.
// Input channel (s_valid/s_ready): one item carries an action (push front,
// push back, pop front, pop back, look; unknown codes look) and a word.
// Result channel (m_valid/m_ready): one result per item with ok, the front
// and rear words after the action (-1 when empty) and empty/full flags.
// Configuration channel (cfg_valid/cfg_data): the capacity, clamped to
// 1..DEPTH; a write is taken at once but only lands while the queue is empty.
// Each accepted item passes through these steps in order: update head,
// count and write the store; read front and rear through the store's
// registered read; load the output register. A new item is taken only
// after the one before it has finished these steps.
// The output register holds a result while the receiver stalls; the block
// takes the next item once the result before it has moved into that register,
// and a finished item waits in place until the register frees.
// Reset (aresetn low, synchronous) empties the queue, sets head to zero and
// capacity to DEPTH; store contents are not cleared and are never read
// before being written, so no clearing pass is needed.
module bounded_double_ended_queue
    import bdeq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // item input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ACT_W-1:0]         s_action,
    input  logic signed [WORD_W-1:0] s_value,
    // capacity write
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         cfg_data,
    // result output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_ok,
    output logic signed [WORD_W-1:0] m_front_value,
    output logic signed [WORD_W-1:0] m_rear_value,
    output logic                     m_is_empty,
    output logic                     m_is_full
);

    bdeq_cmd_t cmd;
    bdeq_sts_t sts;

    // the capacity register is always ready; a write while holding words is dropped
    assign cfg_ready = 1'b1;

    bdeq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bdeq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_action      (s_action),
        .s_value       (s_value),
        .cfg_wr        (cfg_valid & cfg_ready),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full)
    );

endmodule

/* tb/tb_bounded_double_ended_queue.sv */
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue;
    import bdeq_pkg::*;

    localparam int QDEPTH = 1024;
    // Generous ceiling: about 2100 items, each at worst a sender gap, the
    // block's own pace and a stalled receiver, taken many times over.
    localparam int LIMIT  = 400000;
    localparam int SETTLE = 20;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [ACT_W-1:0]         s_action = ACT_LOOK;
    logic signed [WORD_W-1:0] s_value = '0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_data = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_ok;
    logic signed [WORD_W-1:0] m_front_value;
    logic signed [WORD_W-1:0] m_rear_value;
    logic                     m_is_empty;
    logic                     m_is_full;

    bounded_double_ended_queue #(.DEPTH(QDEPTH)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_value       (s_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // What the queue must report after each item.
    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] rear;
        logic              empty;
        logic              full;
    } deque_view_t;

    deque_view_t awaited_views[$];
    int          fail_count = 0;

    // Shadow copy of the queue: ring of words, head position, fill level and
    // the capacity in force. Entries are only ever read after a push wrote them.
    logic [WORD_W-1:0] ring_words[QDEPTH];
    int unsigned       ring_head  = 0;
    int unsigned       held_count = 0;
    int unsigned       cap_limit  = QDEPTH;

    // Apply one action to the shadow queue and return the view after it.
    function automatic deque_view_t step_deque(input logic [ACT_W-1:0] act,
                                               input logic [WORD_W-1:0] word);
        deque_view_t view;
        logic        at_cap;
        logic        none_held;
        at_cap    = (held_count >= cap_limit);
        none_held = (held_count == 0);
        view.ok   = 1'b1;
        case (act)
            ACT_PUSH_FRONT: begin
                if (at_cap) begin
                    view.ok = 1'b0;
                end else begin
                    ring_head = (ring_head == 0) ? QDEPTH - 1 : ring_head - 1;
                    ring_words[ring_head] = word;
                    held_count++;
                end
            end
            ACT_PUSH_BACK: begin
                if (at_cap) begin
                    view.ok = 1'b0;
                end else begin
                    ring_words[(ring_head + held_count) % QDEPTH] = word;
                    held_count++;
                end
            end
            ACT_POP_FRONT: begin
                if (none_held) begin
                    view.ok = 1'b0;
                end else begin
                    ring_head = (ring_head + 1) % QDEPTH;
                    held_count--;
                end
            end
            ACT_POP_BACK: begin
                if (none_held) begin
                    view.ok = 1'b0;
                end else begin
                    held_count--;
                end
            end
            default: ; // look only, unknown codes included
        endcase
        if (held_count != 0) begin
            view.front = ring_words[ring_head];
            view.rear  = ring_words[(ring_head + held_count - 1) % QDEPTH];
        end else begin
            view.front = EMPTY_WORD;
            view.rear  = EMPTY_WORD;
        end
        view.empty = (held_count == 0);
        view.full  = (held_count >= cap_limit);
        return view;
    endfunction

    task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            if (fail_count < 40)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Compare every result taken at this edge against the oldest expectation.
    // Values read here are the ones that stood before the edge.
    always @(posedge aclk) begin : result_check
        deque_view_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_views.size() == 0) begin
                if (fail_count < 40)
                    $display("%0t: result with no item pending, ok=%b front=%h rear=%h",
                             $time, m_ok, m_front_value, m_rear_value);
                fail_count++;
            end else begin
                want = awaited_views.pop_front();
                check_field("ok",          WORD_W'(want.ok),    WORD_W'(m_ok));
                check_field("front_value", want.front,          m_front_value);
                check_field("rear_value",  want.rear,           m_rear_value);
                check_field("is_empty",    WORD_W'(want.empty), WORD_W'(m_is_empty));
                check_field("is_full",     WORD_W'(want.full),  WORD_W'(m_is_full));
            end
        end
    end

    // Receiver back-pressure: switch between wide open, light, heavy and a
    // pulsed pattern, picking a new mode at random when the hold runs out.
    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSED} rx_mode_t;
    rx_mode_t rx_mode  = RX_OPEN;
    int       rx_hold  = 200;
    int       rx_phase = 0;

    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(40, 300);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_OPEN:  m_ready <= 1'b1;
            RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_ready <= ($urandom_range(0, 3) == 0);
            default:  m_ready <= ((rx_phase % 11) < 4);
        endcase
    end

    // Sender pacing: bursts of back-to-back items separated by idle gaps,
    // now and then a long one.
    int burst_left = 0;

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    // Offer one item, hold it until taken, then record what it must produce.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] word);
        pace_sender();
        s_valid  <= 1'b1;
        s_action <= act;
        s_value  <= word;
        do @(posedge aclk); while (!s_ready);
        awaited_views.push_back(step_deque(act, word));
    endtask

    // Drop valid and hold off until every result is back.
    task automatic settle();
        s_valid <= 1'b0;
        while (awaited_views.size() != 0) @(posedge aclk);
    endtask

    // Capacity lands only on an empty queue; zero saturates to one and
    // anything past the depth to the depth.
    task automatic write_capacity(input logic [CAP_W-1:0] raw);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= raw;
        do @(posedge aclk); while (!cfg_ready);
        if (held_count == 0)
            cap_limit = (raw == 0) ? 1 : ((raw > QDEPTH) ? QDEPTH : raw);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        if (r < 96)
            return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
        if (r < 98)
            return ACT_LOOK;
        return ACT_LOOK + 3'($urandom_range(1, 3));
    endfunction

    // Empty the queue with pops, set the capacity, then run a random walk.
    task automatic run_phase(input logic [CAP_W-1:0] raw, input int items, input int push_pct);
        while (held_count != 0)
            send_item($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, rand_word());
        write_capacity(raw);
        repeat (items) send_item(pick_action(push_pct), rand_word());
    endtask

    // Fresh queue at full depth: look, refused pops, unknown codes as looks.
    task automatic test_empty_queue();
        send_item(ACT_LOOK, 32'h0000_0000);
        send_item(ACT_POP_FRONT, 32'h5A5A_5A5A);
        send_item(ACT_POP_BACK, 32'hFFFF_FFFF);
        for (int k = 1; k <= 3; k++)
            send_item(ACT_LOOK + 3'(k), rand_word());
    endtask

    // Capacity zero saturates to one: fill, refuse both pushes, empty again.
    // The first push at the front wraps the head below zero.
    task automatic test_single_slot();
        write_capacity('0);
        send_item(ACT_PUSH_FRONT, 32'h8000_0000);
        send_item(ACT_PUSH_BACK, 32'h0000_0001);
        send_item(ACT_PUSH_FRONT, 32'h0000_0002);
        send_item(ACT_LOOK, 32'h0000_0000);
        send_item(ACT_POP_BACK, 32'h0000_0000);
        send_item(ACT_PUSH_BACK, 32'h7FFF_FFFF);
        send_item(ACT_POP_FRONT, 32'h0000_0000);
    endtask

    // Oversized writes saturate to the depth; then two slots worked from both
    // ends, with a stored -1 that must not read as empty.
    task automatic test_both_ends();
        write_capacity('1);
        write_capacity(11'd1025);
        write_capacity(11'd2);
        send_item(ACT_PUSH_BACK, 32'h0000_0000);
        send_item(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send_item(ACT_PUSH_BACK, 32'h0000_0003);
        send_item(ACT_POP_FRONT, 32'h0000_0000);
        send_item(ACT_POP_BACK, 32'h0000_0000);
    endtask

    // A capacity write while words are held is dropped: capacity stays two.
    task automatic test_write_while_holding();
        send_item(ACT_PUSH_BACK, 32'h1234_5678);
        write_capacity(11'd7);
        send_item(ACT_PUSH_FRONT, 32'h0F0F_0F0F);
        send_item(ACT_PUSH_BACK, 32'h0000_0004);
        send_item(ACT_POP_FRONT, 32'h0000_0000);
        send_item(ACT_POP_BACK, 32'h0000_0000);
    endtask

    // Random walks over small capacities, where full and empty come often.
    task automatic test_random_capacities();
        run_phase(11'd1, 80, 50);
        run_phase(11'd2, 80, 50);
        run_phase(11'd3, 100, 55);
        run_phase(11'($urandom_range(4, 16)), 150, 55);
        run_phase(11'($urandom_range(17, 64)), 200, 60);
        run_phase('0, 60, 50);
    endtask

    // Push-heavy walk at the largest capacity: wrap the ring and reach full.
    task automatic test_fill_to_depth();
        run_phase('1, 1300, 94);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_queue();
        test_single_slot();
        test_both_ends();
        test_write_while_holding();
        test_random_capacities();
        test_fill_to_depth();
        settle();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: count cycles and give up at the limit.
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results pending", $time, awaited_views.size());
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
design/bdeq_pkg.sv
design/bdeq_ram.sv
design/bdeq_ctrl.sv
design/bdeq_dp.sv
design/bounded_double_ended_queue.sv
tb/tb_bounded_double_ended_queue.sv
